// File: hw/rtl/gcdc_pkg.sv
// Shared types, constants and tables for the geographic to dipole rotation core.
package gcdc_pkg;

    localparam int QF          = 30;   // internal fraction bits
    localparam int W           = 36;   // CORDIC word width
    localparam int V_W         = 39;   // scaled input angle width
    localparam int TRIG_W      = 32;   // sine / cosine word width
    localparam int VEC_W       = 34;   // unit vector component width
    localparam int COEF_W      = 17;   // matrix coefficient width
    localparam int MP_W        = COEF_W + VEC_W;
    localparam int ZC_W        = 32;   // clamped z width
    localparam int REM_W       = 62;   // square root remainder width
    localparam int ROOT_W      = 31;   // square root result width
    localparam int DEF_ANGLE_FRAC_BITS = 16;
    localparam int DEF_CORDIC_STAGES   = 18;

    typedef logic signed [W-1:0]      t_word;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef                    t_mat [0:2][0:2];

    localparam t_word Q_ONE      = 36'sd1073741824;
    localparam t_word Q_PI       = 36'sd3373259426;
    localparam t_word Q_HALF_PI  = 36'sd1686629713;
    localparam t_word Q_TWO_PI   = 36'sd6746518853;
    localparam t_word Q_INV_GAIN = 36'sd652032874;

    // 2^44 / (2pi in Q30), rounded, for the quotient estimate of the range reduction
    localparam logic [12:0] RECIP_TWO_PI = 13'd2608;

    localparam t_mat DIP_MAT = '{
        '{17'sd19248, -17'sd61722, -17'sd10716},
        '{17'sd62564,  17'sd19511,  17'sd0},
        '{17'sd3190,  -17'sd10230,  17'sd64654}
    };

    function automatic t_word atan_q30(input int idx);
        t_word a;
        case (idx)
            0:  a = 36'sd843314857;
            1:  a = 36'sd497837829;
            2:  a = 36'sd263043837;
            3:  a = 36'sd133525159;
            4:  a = 36'sd67021687;
            5:  a = 36'sd33543516;
            6:  a = 36'sd16775851;
            7:  a = 36'sd8388437;
            8:  a = 36'sd4194283;
            9:  a = 36'sd2097149;
            10: a = 36'sd1048576;
            11: a = 36'sd524288;
            12: a = 36'sd262144;
            13: a = 36'sd131072;
            14: a = 36'sd65536;
            15: a = 36'sd32768;
            16: a = 36'sd16384;
            17: a = 36'sd8192;
            18: a = 36'sd4096;
            19: a = 36'sd2048;
            20: a = 36'sd1024;
            21: a = 36'sd512;
            22: a = 36'sd256;
            23: a = 36'sd128;
            24: a = 36'sd64;
            25: a = 36'sd32;
            26: a = 36'sd16;
            27: a = 36'sd8;
            28: a = 36'sd4;
            29: a = 36'sd2;
            30: a = 36'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/gcdc_cordic_cell.sv
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
module gcdc_cordic_cell #(
    parameter int SHIFT     = 0,
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  gcdc_pkg::t_word     i_x,
    input  gcdc_pkg::t_word     i_y,
    input  gcdc_pkg::t_word     i_z,
    input  logic [SIDE_W-1:0]   i_side,
    output logic                o_valid,
    output gcdc_pkg::t_word     o_x,
    output gcdc_pkg::t_word     o_y,
    output gcdc_pkg::t_word     o_z,
    output logic [SIDE_W-1:0]   o_side
);
    import gcdc_pkg::*;

    localparam t_word ANGLE = atan_q30(SHIFT);

    t_word dx, dy, n_x, n_y, n_z;
    logic  pos;
    logic  r_valid;
    t_word r_x, r_y, r_z;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        dx  = i_y >>> SHIFT;
        dy  = i_x >>> SHIFT;
        pos = VECTORING ? !(i_y > 0) : (i_z >= 0);
        if (pos) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ANGLE;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// File: hw/rtl/gcdc_sqrt_cell.sv
// One result bit of a pipelined floor square root, registered.
module gcdc_sqrt_cell #(
    parameter int BIT    = 0,
    parameter int SIDE_W = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [gcdc_pkg::REM_W-1:0]        i_rem,
    input  logic [gcdc_pkg::ROOT_W-1:0]       i_root,
    input  logic [SIDE_W-1:0]                 i_side,
    output logic                              o_valid,
    output logic [gcdc_pkg::REM_W-1:0]        o_rem,
    output logic [gcdc_pkg::ROOT_W-1:0]       o_root,
    output logic [SIDE_W-1:0]                 o_side
);
    import gcdc_pkg::*;

    logic [REM_W-1:0]  trial, n_rem;
    logic [ROOT_W-1:0] n_root;
    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [SIDE_W-1:0] r_side;

    // (root + 2^b)^2 - root^2
    always_comb begin
        trial = (REM_W'(i_root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
        if (i_rem >= trial) begin
            n_rem  = i_rem - trial;
            n_root = i_root | (ROOT_W'(1) << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_root <= n_root;
        r_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

// File: hw/rtl/geographic_to_dipole_coords_core.sv
// Top level: geographic to centred-dipole coordinate rotation pipeline.
// Fully pipelined: one item is taken every clock cycle (busy stays low) and its
// result leaves marked by o_strobe for one cycle. The path runs through two
// CORDIC cell chains in series (the sine/cosine pair side by side, then the
// arctangent pair side by side), the 31-cell square root chain and 14
// single-register stages around them. There is no output buffering, since
// the receiver cannot stall: take each result in its strobe cycle or lose it.
// All angles are radians with ANGLE_FRAC_BITS fraction bits.
module geographic_to_dipole_coords_core #(
    parameter int ANGLE_FRAC_BITS = gcdc_pkg::DEF_ANGLE_FRAC_BITS,
    parameter int CORDIC_STAGES   = gcdc_pkg::DEF_CORDIC_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [17:0]        i_geo_colatitude,
    input  logic signed [19:0] i_geo_longitude,
    output logic               o_strobe,
    output logic [17:0]        o_dip_colatitude,
    output logic [18:0]        o_dip_longitude
);
    import gcdc_pkg::*;

    localparam int SH     = QF - ANGLE_FRAC_BITS;
    localparam int NST    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int SQ_SW  = ZC_W + 2 * W;
    localparam logic [W-1:0] ROUND_INC = (W'(1) << SH) >> 1;
    localparam logic [W-1:0] TWO_OUT   = (W'(Q_TWO_PI) + ROUND_INC) >> SH;

    // the block never holds off an item
    assign busy = 1'b0;

    // ---- stage 0: scale both angles to Q30
    logic                  r_vld0;
    logic signed [V_W-1:0] r_v0_col, r_v0_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v0_col <= $signed({{(V_W-18){1'b0}}, i_geo_colatitude}) <<< SH;
        r_v0_lon <= V_W'(i_geo_longitude) <<< SH;
    end

    // ---- stage 1: estimate the whole number of turns from the top bits
    logic                  r_vld1;
    logic signed [V_W-1:0] r_v1_col, r_v1_lon;
    logic signed [7:0]     r_q1_col, r_q1_lon;
    logic signed [V_W-29:0] t_col, t_lon;
    logic signed [24:0]    qp_col, qp_lon;

    always_comb begin
        t_col  = (V_W-28)'(r_v0_col >>> 28);
        t_lon  = (V_W-28)'(r_v0_lon >>> 28);
        qp_col = 25'(t_col) * $signed({12'b0, RECIP_TWO_PI});
        qp_lon = 25'(t_lon) * $signed({12'b0, RECIP_TWO_PI});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= r_vld0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v1_col <= r_v0_col;
        r_v1_lon <= r_v0_lon;
        r_q1_col <= 8'(qp_col >>> 16);
        r_q1_lon <= 8'(qp_lon >>> 16);
    end

    // ---- stage 2: subtract the turns
    logic               r_vld2;
    logic signed [41:0] r_r2_col, r_r2_lon;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2_col <= 42'(r_v1_col) - 42'(r_q1_col) * 42'(Q_TWO_PI);
        r_r2_lon <= 42'(r_v1_lon) - 42'(r_q1_lon) * 42'(Q_TWO_PI);
    end

    // ---- stage 3: correct the estimate by one turn, move into [-pi, pi)
    logic  r_vld3;
    t_word r_r3_col, r_r3_lon;

    function automatic t_word wrap_turn(input logic signed [41:0] r);
        logic signed [41:0] a;
        a = r;
        if (a < 0) begin
            a = a + 42'(Q_TWO_PI);
        end else if (a >= 42'(Q_TWO_PI)) begin
            a = a - 42'(Q_TWO_PI);
        end
        if (a >= 42'(Q_PI)) begin
            a = a - 42'(Q_TWO_PI);
        end
        return W'(a);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
        end else begin
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r3_col <= wrap_turn(r_r2_col);
        r_r3_lon <= wrap_turn(r_r2_lon);
    end

    // ---- stage 4: fold into [-pi/2, pi/2], note the sign flip
    logic  r_vld4;
    t_word r_r4_col, r_r4_lon;
    logic  r_neg4_col, r_neg4_lon;
    t_word f_col, f_lon;
    logic  fn_col, fn_lon;

    always_comb begin
        f_col  = r_r3_col;
        fn_col = 1'b0;
        if (r_r3_col > Q_HALF_PI) begin
            f_col  = r_r3_col - Q_PI;
            fn_col = 1'b1;
        end else if (r_r3_col < -Q_HALF_PI) begin
            f_col  = r_r3_col + Q_PI;
            fn_col = 1'b1;
        end
        f_lon  = r_r3_lon;
        fn_lon = 1'b0;
        if (r_r3_lon > Q_HALF_PI) begin
            f_lon  = r_r3_lon - Q_PI;
            fn_lon = 1'b1;
        end else if (r_r3_lon < -Q_HALF_PI) begin
            f_lon  = r_r3_lon + Q_PI;
            fn_lon = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
        end else begin
            r_vld4 <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r4_col   <= f_col;
        r_r4_lon   <= f_lon;
        r_neg4_col <= fn_col;
        r_neg4_lon <= fn_lon;
    end

    // ---- sine / cosine: two rotation chains side by side
    logic  cs_vld [0:NST];
    t_word cc_x [0:NST], cc_y [0:NST], cc_z [0:NST];
    t_word cl_x [0:NST], cl_y [0:NST], cl_z [0:NST];
    logic [1:0] cs_side [0:NST];
    logic  cl_vld_unused [1:NST];
    logic [1:0] cl_side_unused [1:NST];

    assign cs_vld[0]  = r_vld4;
    assign cc_x[0]    = Q_INV_GAIN;
    assign cc_y[0]    = '0;
    assign cc_z[0]    = r_r4_col;
    assign cl_x[0]    = Q_INV_GAIN;
    assign cl_y[0]    = '0;
    assign cl_z[0]    = r_r4_lon;
    assign cs_side[0] = {r_neg4_col, r_neg4_lon};

    for (genvar i = 0; i < NST; i++) begin : g_sc
        gcdc_cordic_cell #(.SHIFT(i), .VECTORING(1'b0), .SIDE_W(2)) u_col (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cs_vld[i]),
            .i_x(cc_x[i]), .i_y(cc_y[i]), .i_z(cc_z[i]), .i_side(cs_side[i]),
            .o_valid(cs_vld[i+1]), .o_x(cc_x[i+1]), .o_y(cc_y[i+1]),
            .o_z(cc_z[i+1]), .o_side(cs_side[i+1])
        );
        gcdc_cordic_cell #(.SHIFT(i), .VECTORING(1'b0), .SIDE_W(2)) u_lon (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cs_vld[i]),
            .i_x(cl_x[i]), .i_y(cl_y[i]), .i_z(cl_z[i]), .i_side(cs_side[i]),
            .o_valid(cl_vld_unused[i+1]), .o_x(cl_x[i+1]), .o_y(cl_y[i+1]),
            .o_z(cl_z[i+1]), .o_side(cl_side_unused[i+1])
        );
    end

    // ---- stage P1: apply the fold sign, narrow to the trig width
    logic                     r_vldp1;
    logic signed [TRIG_W-1:0] r_ct, r_st, r_cp, r_sp;
    logic                     ng_col, ng_lon;

    assign ng_col = cs_side[NST][1];
    assign ng_lon = cs_side[NST][0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldp1 <= 1'b0;
        end else begin
            r_vldp1 <= cs_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ct <= TRIG_W'(ng_col ? -cc_x[NST] : cc_x[NST]);
        r_st <= TRIG_W'(ng_col ? -cc_y[NST] : cc_y[NST]);
        r_cp <= TRIG_W'(ng_lon ? -cl_x[NST] : cl_x[NST]);
        r_sp <= TRIG_W'(ng_lon ? -cl_y[NST] : cl_y[NST]);
    end

    // ---- stage P2: geographic unit vector
    logic                    r_vldp2;
    logic signed [VEC_W-1:0] r_vec [0:2];
    logic signed [63:0]      pxy_x, pxy_y;

    always_comb begin
        pxy_x = 64'(r_st) * 64'(r_cp);
        pxy_y = 64'(r_st) * 64'(r_sp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldp2 <= 1'b0;
        end else begin
            r_vldp2 <= r_vldp1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec[0] <= VEC_W'(pxy_x >>> QF);
        r_vec[1] <= VEC_W'(pxy_y >>> QF);
        r_vec[2] <= VEC_W'(r_ct);
    end

    // ---- stage M1: matrix products
    logic                   r_vldm1;
    logic signed [MP_W-1:0] r_mp [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldm1 <= 1'b0;
        end else begin
            r_vldm1 <= r_vldp2;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
                r_mp[k][j] <= MP_W'(DIP_MAT[k][j]) * MP_W'(r_vec[j]);
            end
        end
    end

    // ---- stage M2: row sums back to Q30
    logic  r_vldm2;
    t_word r_rot [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldm2 <= 1'b0;
        end else begin
            r_vldm2 <= r_vldm1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_rot[k] <= W'(((MP_W+2)'(r_mp[k][0]) + (MP_W+2)'(r_mp[k][1])
                           + (MP_W+2)'(r_mp[k][2])) >>> 16);
        end
    end

    // ---- stage Z1: clamp z to [-1, 1]
    logic                   r_vldz1;
    logic signed [ZC_W-1:0] r_zc1;
    t_word                  r_x_z1, r_y_z1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldz1 <= 1'b0;
        end else begin
            r_vldz1 <= r_vldm2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rot[2] > Q_ONE) begin
            r_zc1 <= ZC_W'(Q_ONE);
        end else if (r_rot[2] < -Q_ONE) begin
            r_zc1 <= ZC_W'(-Q_ONE);
        end else begin
            r_zc1 <= ZC_W'(r_rot[2]);
        end
        r_x_z1 <= r_rot[0];
        r_y_z1 <= r_rot[1];
    end

    // ---- stage Z2: radicand 1 - z^2 in Q60
    logic                   r_vldz2;
    logic [REM_W-1:0]       r_rad;
    logic [SQ_SW-1:0]       r_side_z2;
    logic signed [63:0]     zz;

    assign zz = 64'(r_zc1) * 64'(r_zc1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldz2 <= 1'b0;
        end else begin
            r_vldz2 <= r_vldz1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad     <= REM_W'((64'sd1 <<< 60) - zz);
        r_side_z2 <= {r_zc1, r_x_z1, r_y_z1};
    end

    // ---- square root chain, one result bit per cell from the top
    logic              sq_vld  [0:ROOT_W];
    logic [REM_W-1:0]  sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0] sq_root [0:ROOT_W];
    logic [SQ_SW-1:0]  sq_side [0:ROOT_W];

    assign sq_vld[0]  = r_vldz2;
    assign sq_rem[0]  = r_rad;
    assign sq_root[0] = '0;
    assign sq_side[0] = r_side_z2;

    for (genvar b = 0; b < ROOT_W; b++) begin : g_sq
        gcdc_sqrt_cell #(.BIT(ROOT_W - 1 - b), .SIDE_W(SQ_SW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(sq_vld[b]),
            .i_rem(sq_rem[b]), .i_root(sq_root[b]), .i_side(sq_side[b]),
            .o_valid(sq_vld[b+1]), .o_rem(sq_rem[b+1]), .o_root(sq_root[b+1]),
            .o_side(sq_side[b+1])
        );
    end

    // ---- stage V0: set up both vectoring runs (theta and phi)
    logic                   r_vldv0;
    t_word                  r_tx0, r_ty0, r_tz0, r_px0, r_py0, r_pz0;
    logic [1:0]             r_zero0;
    logic signed [ZC_W-1:0] s_zc;
    t_word                  s_tx, s_ty, s_px, s_py;

    always_comb begin
        s_zc = $signed(sq_side[ROOT_W][SQ_SW-1 -: ZC_W]);
        s_tx = W'(s_zc);
        s_ty = W'({1'b0, sq_root[ROOT_W]});
        s_px = $signed(sq_side[ROOT_W][2*W-1 -: W]);
        s_py = $signed(sq_side[ROOT_W][W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldv0 <= 1'b0;
        end else begin
            r_vldv0 <= sq_vld[ROOT_W];
        end
    end

    // flip left half-plane vectors into the right, start from +/- pi
    always_ff @(posedge i_clk) begin
        r_zero0 <= {(s_tx == '0) && (s_ty == '0), (s_px == '0) && (s_py == '0)};
        if (s_tx < 0) begin
            r_tx0 <= -s_tx;
            r_ty0 <= -s_ty;
            r_tz0 <= (s_ty >= 0) ? Q_PI : -Q_PI;
        end else begin
            r_tx0 <= s_tx;
            r_ty0 <= s_ty;
            r_tz0 <= '0;
        end
        if (s_px < 0) begin
            r_px0 <= -s_px;
            r_py0 <= -s_py;
            r_pz0 <= (s_py >= 0) ? Q_PI : -Q_PI;
        end else begin
            r_px0 <= s_px;
            r_py0 <= s_py;
            r_pz0 <= '0;
        end
    end

    // ---- arctangent chains
    logic       at_vld [0:NST];
    t_word      ta_x [0:NST], ta_y [0:NST], ta_z [0:NST];
    t_word      pa_x [0:NST], pa_y [0:NST], pa_z [0:NST];
    logic [1:0] at_side [0:NST];
    logic       pa_vld_unused [1:NST];
    logic [1:0] pa_side_unused [1:NST];

    assign at_vld[0]  = r_vldv0;
    assign ta_x[0]    = r_tx0;
    assign ta_y[0]    = r_ty0;
    assign ta_z[0]    = r_tz0;
    assign pa_x[0]    = r_px0;
    assign pa_y[0]    = r_py0;
    assign pa_z[0]    = r_pz0;
    assign at_side[0] = r_zero0;

    for (genvar i = 0; i < NST; i++) begin : g_at
        gcdc_cordic_cell #(.SHIFT(i), .VECTORING(1'b1), .SIDE_W(2)) u_th (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(at_vld[i]),
            .i_x(ta_x[i]), .i_y(ta_y[i]), .i_z(ta_z[i]), .i_side(at_side[i]),
            .o_valid(at_vld[i+1]), .o_x(ta_x[i+1]), .o_y(ta_y[i+1]),
            .o_z(ta_z[i+1]), .o_side(at_side[i+1])
        );
        gcdc_cordic_cell #(.SHIFT(i), .VECTORING(1'b1), .SIDE_W(2)) u_ph (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(at_vld[i]),
            .i_x(pa_x[i]), .i_y(pa_y[i]), .i_z(pa_z[i]), .i_side(at_side[i]),
            .o_valid(pa_vld_unused[i+1]), .o_x(pa_x[i+1]), .o_y(pa_y[i+1]),
            .o_z(pa_z[i+1]), .o_side(pa_side_unused[i+1])
        );
    end

    // ---- stage F1: zero vector, clamp theta to [0, pi], wrap phi to [0, 2pi)
    logic         r_vldf1;
    logic [W-1:0] r_th1, r_ph1;
    t_word        th, ph;

    always_comb begin
        th = at_side[NST][1] ? '0 : ta_z[NST];
        if (th < 0) begin
            th = '0;
        end
        if (th > Q_PI) begin
            th = Q_PI;
        end
        ph = at_side[NST][0] ? '0 : pa_z[NST];
        if (ph < 0) begin
            ph = ph + Q_TWO_PI;
        end
        if (ph >= Q_TWO_PI) begin
            ph = ph - Q_TWO_PI;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vldf1 <= 1'b0;
        end else begin
            r_vldf1 <= at_vld[NST];
        end
    end

    always_ff @(posedge i_clk) begin
        r_th1 <= W'(th);
        r_ph1 <= W'(ph);
    end

    // ---- stage F2: round half up to the output format, wrap 2pi to 0
    logic         r_strobe;
    logic [17:0]  r_dip_col;
    logic [18:0]  r_dip_lon;
    logic [W-1:0] oth, oph;

    always_comb begin
        oth = (r_th1 + ROUND_INC) >> SH;
        oph = (r_ph1 + ROUND_INC) >> SH;
        if (oph >= TWO_OUT) begin
            oph = oph - TWO_OUT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_vldf1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dip_col <= oth[17:0];
        r_dip_lon <= oph[18:0];
    end

    assign o_strobe         = r_strobe;
    assign o_dip_colatitude = r_dip_col;
    assign o_dip_longitude  = r_dip_lon;

endmodule
